@@ src/arls_pkg.sv @@
package arls_pkg;

  // Operation codes of a request.
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_TRIM   = 1'b1;

  // Status codes of a result.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [63:0] range_start_in;
    logic [63:0] range_end_in;
    logic [63:0] trim_address;
    logic [63:0] instruction_size;
    logic [3:0]  search_hint;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        has_range;
    logic [63:0] range_start_out;
    logic [63:0] range_end_out;
    logic [4:0]  ranges_kept;
    logic        last;
  } rsp_t;

endpackage

@@ src/arls_chan_if.sv @@
interface arls_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ src/address_range_list_split.sv @@
// Sequence: an append request has its result loaded into the output register at its accepting edge.
// A trim checks a usable hint, scans ranges with a read and a compare state each, loads a split
// tail if one is found, then reads and loads each range removed, or loads one empty result when
// nothing matches. One request at a time: a trim holds the input until its last result is loaded,
// and the one read port of each list memory sets its pace.
// Reset: the sequencer goes to idle, the output empties and the count clears; memories are not.
module address_range_list_split #(
  parameter int DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  arls_chan_if.sink   req_i,
  arls_chan_if.source rsp_o
);

  // Width of the count (it must hold DEPTH itself) and of a memory address.
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  // Width used to compare the four-bit hint against the count.
  localparam int HW = (CW > 4) ? CW : 4;

  // Sequencer state codes.
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_HINT_CHK = 4'd1;
  localparam logic [3:0] ST_SCAN_RD  = 4'd2;
  localparam logic [3:0] ST_SCAN_CMP = 4'd3;
  localparam logic [3:0] ST_TAIL_OUT = 4'd4;
  localparam logic [3:0] ST_EMIT_RD  = 4'd5;
  localparam logic [3:0] ST_EMIT_OUT = 4'd6;
  localparam logic [3:0] ST_DONE_OUT = 4'd7;

  // The range list lives in two memories, one for the starts and one for the ends.
  // Each has one write port and one registered read port; the read runs every cycle.
  logic [63:0] starts_mem [DEPTH];
  logic [63:0] ends_mem [DEPTH];

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;   // ranges held (after a trim: the count left)
  logic [CW-1:0] old_q, old_d;       // count before the current trim
  logic [CW-1:0] idx_q, idx_d;       // scan or emit position
  logic [63:0]   trim_q, trim_d;
  logic [63:0]   isz_q, isz_d;
  logic [3:0]    hint_q, hint_d;
  logic [63:0]   tail_e_q, tail_e_d;

  logic [AW-1:0] rd_addr;
  logic [63:0]   rd_s_q, rd_e_q;
  logic          wr_s_en, wr_e_en;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_s_data, wr_e_data;

  arls_pkg::rsp_t out_q, out_d;
  logic           out_valid_q, out_valid_d;
  logic           out_free;
  logic           out_load;

  logic           accept;
  logic           hint_usable;
  logic           tail_hit;
  logic           start_hit;

  // The output register can take a new result when it is empty or being drained.
  assign out_free = !out_valid_q || rsp_o.ready;

  // A new request is taken only in idle and when its result could be stored at once.
  assign req_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept      = req_i.valid && req_i.ready;

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  // The hint is usable when it is nonzero and points at a held range.
  assign hint_usable = (req_i.payload.search_hint != 4'd0) &&
                       (HW'(req_i.payload.search_hint) < HW'(count_q));

  // Match tests on the range read back from memory.
  assign start_hit = (trim_q == rd_s_q);
  assign tail_hit  = (trim_q > rd_s_q) && (trim_q <= rd_e_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    old_d       = old_q;
    idx_d       = idx_q;
    trim_d      = trim_q;
    isz_d       = isz_q;
    hint_d      = hint_q;
    tail_e_d    = tail_e_q;
    out_d       = out_q;
    out_load    = 1'b0;
    wr_s_en     = 1'b0;
    wr_e_en     = 1'b0;
    wr_addr     = count_q[AW-1:0];
    wr_s_data   = req_i.payload.range_start_in;
    wr_e_data   = req_i.payload.range_end_in;
    rd_addr     = idx_q[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        // The hint entry is read now so it can be checked in the next cycle.
        rd_addr = AW'(req_i.payload.search_hint);
        if (accept) begin
          if (req_i.payload.operation == arls_pkg::OP_APPEND) begin
            out_load              = 1'b1;
            out_d.has_range       = 1'b0;
            out_d.range_start_out = 64'd0;
            out_d.range_end_out   = 64'd0;
            out_d.last            = 1'b1;
            if (count_q < CW'(DEPTH)) begin
              wr_s_en           = 1'b1;
              wr_e_en           = 1'b1;
              count_d           = count_q + CW'(1);
              out_d.status      = arls_pkg::STATUS_OK;
              out_d.ranges_kept = 5'(count_q + CW'(1));
            end else begin
              out_d.status      = arls_pkg::STATUS_FULL;
              out_d.ranges_kept = 5'(count_q);
            end
          end else begin
            trim_d = req_i.payload.trim_address;
            isz_d  = req_i.payload.instruction_size;
            hint_d = req_i.payload.search_hint;
            old_d  = count_q;
            idx_d  = '0;
            if (hint_usable) begin
              state_d = ST_HINT_CHK;
            end else begin
              state_d = ST_SCAN_RD;
            end
          end
        end
      end

      ST_HINT_CHK: begin
        // The hinted range must hold the trim address, its start included.
        if ((trim_q >= rd_s_q) && (trim_q <= rd_e_q)) begin
          idx_d = CW'(hint_q);
        end
        state_d = ST_SCAN_RD;
      end

      ST_SCAN_RD: begin
        if (idx_q >= count_q) begin
          // No range matched: the list stays as it is.
          state_d = ST_DONE_OUT;
        end else begin
          state_d = ST_SCAN_CMP;
        end
      end

      ST_SCAN_CMP: begin
        if (start_hit) begin
          // This range and every later one leave the list whole.
          count_d = idx_q;
          state_d = ST_EMIT_RD;
        end else if (tail_hit) begin
          // Split the range: the tail is emitted, the head ends before the instruction.
          wr_e_en   = 1'b1;
          wr_addr   = idx_q[AW-1:0];
          wr_e_data = trim_q - isz_q;
          tail_e_d  = rd_e_q;
          count_d   = idx_q + CW'(1);
          idx_d     = idx_q + CW'(1);
          state_d   = ST_TAIL_OUT;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = ST_SCAN_RD;
        end
      end

      ST_TAIL_OUT: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_d.status          = arls_pkg::STATUS_OK;
          out_d.has_range       = 1'b1;
          out_d.range_start_out = trim_q;
          out_d.range_end_out   = tail_e_q;
          out_d.ranges_kept     = 5'(count_q);
          out_d.last            = (count_q == old_q);
          if (count_q == old_q) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_EMIT_RD;
          end
        end
      end

      ST_EMIT_RD: begin
        state_d = ST_EMIT_OUT;
      end

      ST_EMIT_OUT: begin
        // The read address stays on idx, so the data holds while the output stalls.
        if (out_free) begin
          out_load              = 1'b1;
          out_d.status          = arls_pkg::STATUS_OK;
          out_d.has_range       = 1'b1;
          out_d.range_start_out = rd_s_q;
          out_d.range_end_out   = rd_e_q;
          out_d.ranges_kept     = 5'(count_q);
          out_d.last            = ((idx_q + CW'(1)) == old_q);
          idx_d                 = idx_q + CW'(1);
          if ((idx_q + CW'(1)) == old_q) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_EMIT_RD;
          end
        end
      end

      ST_DONE_OUT: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_d.status          = arls_pkg::STATUS_OK;
          out_d.has_range       = 1'b0;
          out_d.range_start_out = 64'd0;
          out_d.range_end_out   = 64'd0;
          out_d.ranges_kept     = 5'(count_q);
          out_d.last            = 1'b1;
          state_d               = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    old_q    <= old_d;
    idx_q    <= idx_d;
    trim_q   <= trim_d;
    isz_q    <= isz_d;
    hint_q   <= hint_d;
    tail_e_q <= tail_e_d;
    out_q    <= out_d;
  end

  // Range memories: one write port, one registered read port each.
  always_ff @(posedge clk_i) begin
    if (wr_s_en) begin
      starts_mem[wr_addr] <= wr_s_data;
    end
    rd_s_q <= starts_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_e_en) begin
      ends_mem[wr_addr] <= wr_e_data;
    end
    rd_e_q <= ends_mem[rd_addr];
  end

endmodule

@@ tb/arls_scoreboard_pkg.sv @@
package arls_scoreboard_pkg;

  import arls_pkg::*;

  localparam int LIST_DEPTH = 16;

  // Mirror of the range list that predicts every result a request causes.
  class arls_scoreboard;
    logic [63:0] starts[LIST_DEPTH];
    logic [63:0] ends[LIST_DEPTH];
    int          count;
    rsp_t        expected_q[$];

    int errors;
    int appends;
    int dropped;
    int trims;
    int tails;
    int misses;
    int checked;

    function rsp_t make_rsp(logic st, logic has, logic [63:0] s, logic [63:0] e, logic lst);
      rsp_t r;
      r.status          = st;
      r.has_range       = has;
      r.range_start_out = s;
      r.range_end_out   = e;
      r.ranges_kept     = count[4:0];
      r.last            = lst;
      return r;
    endfunction

    // Adds a predicted result behind the ones already waiting.
    function void queue_rsp(rsp_t r);
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void note_request(req_t r);
      logic [63:0] trim;
      logic [63:0] tail_e;
      int          first;
      int          cut;
      int          old;
      int          total;
      int          n;
      int          h;
      bit          have_tail;
      trim = r.trim_address;
      if (r.operation == OP_APPEND) begin
        appends++;
        if (count < LIST_DEPTH) begin
          starts[count] = r.range_start_in;
          ends[count]   = r.range_end_in;
          count++;
          queue_rsp(make_rsp(STATUS_OK, 1'b0, '0, '0, 1'b1));
        end else begin
          dropped++;
          queue_rsp(make_rsp(STATUS_FULL, 1'b0, '0, '0, 1'b1));
        end
        return;
      end
      trims++;
      first = 0;
      h = int'(r.search_hint);
      if (h > 0 && h < count && trim >= starts[h] && trim <= ends[h]) begin
        first = h;
      end
      cut = count;
      have_tail = 1'b0;
      tail_e = '0;
      for (int i = first; i < count; i++) begin
        if (trim == starts[i]) begin
          cut = i;
          break;
        end
        if (trim > starts[i] && trim <= ends[i]) begin
          have_tail = 1'b1;
          tail_e = ends[i];
          ends[i] = trim - r.instruction_size;
          cut = i + 1;
          break;
        end
      end
      old = count;
      total = int'(have_tail) + old - cut;
      count = cut;
      if (total == 0) begin
        misses++;
        queue_rsp(make_rsp(STATUS_OK, 1'b0, '0, '0, 1'b1));
        return;
      end
      n = 0;
      if (have_tail) begin
        tails++;
        n++;
        queue_rsp(make_rsp(STATUS_OK, 1'b1, trim, tail_e, n == total));
      end
      for (int i = cut; i < old; i++) begin
        n++;
        queue_rsp(make_rsp(STATUS_OK, 1'b1, starts[i], ends[i], n == total));
      end
    endfunction

    function void report_field(string field, logic [63:0] want, logic [63:0] seen, realtime t);
      if (want !== seen) begin
        errors++;
        $display("%0.1f ns: %s mismatch, expected %0h, actual %0h", t, field, want, seen);
      end
    endfunction

    function void check_response(rsp_t got, realtime t);
      rsp_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0.1f ns: unexpected result, expected none, actual %0h", t, got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      report_field("status", want.status, got.status, t);
      report_field("has_range", want.has_range, got.has_range, t);
      report_field("range_start_out", want.range_start_out, got.range_start_out, t);
      report_field("range_end_out", want.range_end_out, got.range_end_out, t);
      report_field("ranges_kept", want.ranges_kept, got.ranges_kept, t);
      report_field("last", want.last, got.last, t);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

@@ tb/tb_address_range_list_split.sv @@
// Testbench of the address range list. Requests are driven on one channel and results
// collected on the other, both with random idle gaps. A scoreboard mirrors the list,
// predicts every result of each accepted request and checks the results in order.
module tb_address_range_list_split;

  timeunit 1ns;
  timeprecision 1ps;

  import arls_pkg::*;
  import arls_scoreboard_pkg::*;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // Number of random requests to send after the directed part.
  localparam int RANDOM_REQUESTS = 230;

  // Cycles to keep watching the result channel after the last expected result, so that any
  // stray trailing result is seen.
  localparam int TAIL_CYCLES = 80;

  logic clk_i;
  logic rst_ni;

  arls_chan_if #(.payload_t(req_t)) req_if ();
  arls_chan_if #(.payload_t(rsp_t)) rsp_if ();

  address_range_list_split #(
    .DEPTH(LIST_DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  arls_scoreboard sb = new();

  // When set, both sides run back to back so that stretches without idling occur.
  bit quiet;
  int sent;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Drives one request and returns at the clock edge where it is accepted. The valid
  // line is left high so that a following request with no gap goes out in the next
  // cycle; whoever pauses the sender afterwards lowers it first.
  task automatic send_request(input req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.payload <= r;
    req_if.valid   <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(r);
    sent++;
  endtask

  // An append request; the trim fields are unused and carry random bits.
  task automatic send_append(input logic [63:0] s, input logic [63:0] e);
    req_t r;
    r.operation        = OP_APPEND;
    r.range_start_in   = s;
    r.range_end_in     = e;
    r.trim_address     = rand64();
    r.instruction_size = rand64();
    r.search_hint      = 4'($urandom());
    send_request(r);
  endtask

  // A trim request; the range fields are unused and carry random bits.
  task automatic send_trim(input logic [63:0] addr, input logic [63:0] isz,
                           input logic [3:0] hint);
    req_t r;
    r.operation        = OP_TRIM;
    r.range_start_in   = rand64();
    r.range_end_in     = rand64();
    r.trim_address     = addr;
    r.instruction_size = isz;
    r.search_hint      = hint;
    send_request(r);
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  // Appends a batch of ordered ranges and then trims at addresses taken from the
  // list: at a start, inside, at an end, just below a start, or anywhere at all.
  task automatic run_list_episode();
    logic [63:0] base;
    logic [63:0] s;
    logic [63:0] len;
    logic [63:0] addr;
    logic [63:0] isz;
    logic [3:0]  hint;
    int          n;
    int          idx;
    int          ntrims;
    n = (sb.count < LIST_DEPTH) ? $urandom_range(1, LIST_DEPTH - sb.count) : 0;
    base = (sb.count > 0) ? sb.ends[sb.count - 1] + 1 :
           ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 4096));
    for (int i = 0; i < n; i++) begin
      s = base + 64'($urandom_range(0, 64));
      len = ($urandom_range(0, 7) == 0) ? 64'($urandom()) : 64'($urandom_range(0, 300));
      send_append(s, s + len);
      base = s + len + 1;
    end
    ntrims = $urandom_range(1, 3);
    for (int k = 0; k < ntrims; k++) begin
      isz = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(1, 15));
      if (sb.count == 0) begin
        send_trim(rand64(), isz, 4'($urandom()));
        continue;
      end
      idx = $urandom_range(0, sb.count - 1);
      case ($urandom_range(0, 4))
        0: begin
          addr = sb.starts[idx];
        end
        1: begin
          len = sb.ends[idx] - sb.starts[idx];
          addr = (len == 0) ? sb.starts[idx] : sb.starts[idx] + 1 + (rand64() % len);
        end
        2: begin
          addr = sb.ends[idx];
        end
        3: begin
          addr = rand64();
        end
        default: begin
          addr = sb.starts[idx] - 1;
        end
      endcase
      hint = $urandom_range(0, 1) ? 4'(idx) : 4'($urandom());
      send_trim(addr, isz, hint);
    end
  endtask

  // Fills the list to the top, pushes one or two appends that must be dropped, and
  // then cuts the list back at a random stored start.
  task automatic fill_and_overflow();
    logic [63:0] base;
    base = rand64();
    while (sb.count < LIST_DEPTH) begin
      send_append(base, base + 64'($urandom_range(0, 200)));
      base = base + 64'($urandom_range(201, 600));
    end
    repeat ($urandom_range(1, 2)) send_append(rand64(), rand64());
    send_trim(sb.starts[$urandom_range(0, LIST_DEPTH - 1)], rand64(), 4'($urandom()));
  endtask

  // Fully random requests; most trims of this kind miss the list.
  task automatic send_noise();
    req_t r;
    r.operation        = 1'($urandom());
    r.range_start_in   = rand64();
    r.range_end_in     = rand64();
    r.trim_address     = rand64();
    r.instruction_size = rand64();
    r.search_hint      = 4'($urandom());
    send_request(r);
  endtask

  // Result side: stalls at random before each result and checks it once accepted.
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      sb.check_response(rsp_if.payload, $realtime);
    end
  end

  // Request side: reset, the directed cases, then the random episodes.
  initial begin
    int start_count;
    int episode;
    int pick;
    quiet = 1'b0;
    sent = 0;
    rst_ni <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.payload <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A trim on the empty list finds nothing.
    send_trim(ALL_ONES, ALL_ONES, 4'hF);
    // Sixteen aligned ranges; the last one reaches the top of the address space.
    for (int i = 0; i < LIST_DEPTH - 1; i++) begin
      send_append(64'(i * 256), 64'(i * 256 + 255));
    end
    send_append(64'hFFFF_FFFF_FFFF_FF00, ALL_ONES);
    // The list is full, so this append is dropped.
    send_append(ALL_ONES, 64'h0);
    // A usable hint, trim at the last address of a range, and the new end wraps below zero.
    send_trim(64'h5FF, 64'h600, 4'd5);
    // The hinted range does not hold the address, so the scan starts at the front
    // and stops at a range start.
    send_trim(64'h300, 64'h1, 4'd4);
    // An address beyond every stored range.
    send_trim(64'h1000, 64'h1, 4'd0);
    // The hinted range does not hold the address, which is the start of the first range.
    send_trim(64'h0, 64'h1, 4'd1);
    // Extreme single-address range, trimmed at its start.
    send_append(ALL_ONES, ALL_ONES);
    send_trim(ALL_ONES, 64'h0, 4'd0);
    // Inside a range with a zero instruction size, then the remainder at its start.
    send_append(64'd10, 64'd20);
    send_trim(64'd15, 64'h0, 4'd0);
    send_trim(64'd10, rand64(), 4'd0);

    // Hold off until the directed part has fully drained.
    drain_results();

    start_count = sent;
    episode = 0;
    while (sent - start_count < RANDOM_REQUESTS) begin
      quiet = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        run_list_episode();
      end else if (pick < 82) begin
        fill_and_overflow();
      end else begin
        repeat ($urandom_range(1, 4)) send_noise();
      end
      episode++;
      if (episode % 8 == 0) begin
        drain_results();
      end
    end

    req_if.valid <= 1'b0;
    quiet = 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d appends (%0d dropped on a full list) and %0d trims",
             sb.appends, sb.dropped, sb.trims);
    $display("(%0d with a split tail, %0d without a match); %0d results checked.",
             sb.tails, sb.misses, sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, so only a hang lands here.
  initial begin
    #6_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
